// ===== rtl/core/twlm_pkg.sv =====
package twlm_pkg;

    localparam int DIGEST_W = 160;
    localparam int LINE_W   = 6;

    localparam logic [1:0] FILE_ORIG = 2'd0;
    localparam logic [1:0] FILE_A    = 2'd1;
    localparam logic [1:0] FILE_B    = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    localparam logic [1:0] KIND_A        = 2'd0;
    localparam logic [1:0] KIND_B        = 2'd1;
    localparam logic [1:0] KIND_CONFLICT = 2'd2;

    typedef struct packed {
        logic        func;
        logic [1:0]  which_file;
        logic [63:0] digest_high;
        logic [63:0] digest_middle;
        logic [31:0] digest_low;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] a_line;
        logic [5:0] b_line;
        logic [5:0] conflict_total;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_TRACE_RD,
        ST_TRACE_DO,
        ST_MERGE_RD,
        ST_MERGE_DO,
        ST_EMIT,
        ST_CLEAR
    } state_t;

endpackage

// ===== rtl/core/three_way_line_merge_top.sv =====
// Channel  | Direction | Payload    | Handshake
// in       | input     | in_item_t  | in_valid / in_stall
// out      | output    | out_item_t | out_valid / out_stall
//
// A load item is taken in ST_IDLE and leaves the block idle. A run item fills each suffix
// LCS table one cell per ST_FILL_RD/ST_FILL_WR pair, reading the table at two addresses a
// cycle and holding the right neighbor from the previous cell of the row, then walks a
// traceback per table and a merge that gives one result per step.
// Reset clears counters and control; the table is cleared only where it is read
// (border cells are forced to zero), so there is no clearing pass.
// A stalled result holds the sequencer; the block takes no item during a run.
module three_way_line_merge_top
    import twlm_pkg::*;
#(
    parameter int MAX_LINES = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int IW   = $clog2(MAX_LINES + 1);
    localparam int AW   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int SIDE = MAX_LINES + 1;
    localparam int TW   = $clog2(SIDE * SIDE);

    logic [DIGEST_W-1:0] orig_mem [MAX_LINES];
    logic [DIGEST_W-1:0] a_mem    [MAX_LINES];
    logic [DIGEST_W-1:0] b_mem    [MAX_LINES];
    logic [DIGEST_W-1:0] coa_mem  [MAX_LINES];
    logic [DIGEST_W-1:0] cob_mem  [MAX_LINES];
    logic [DIGEST_W-1:0] call_mem [MAX_LINES];
    logic [IW-1:0]       tbl      [SIDE*SIDE];

    state_t state_reg, state_next;
    logic [IW-1:0] cnt_reg [3];
    logic [IW-1:0] cc_reg  [3];
    logic [1:0]    pass_reg, pass_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, n_reg, n_next;
    logic [IW-1:0] ac_reg, ac_next, bc_reg, bc_next, a1_reg, a1_next;
    logic [IW-1:0] b1_reg, b1_next, lc_reg, lc_next, er_reg, er_next;
    logic [IW-1:0] prev_reg, prev_next;
    out_item_t     res_reg, res_next;

    logic [DIGEST_W-1:0] xd, yd, x_q, y_q, ca_q, coa_q, cob_q;
    logic [IW-1:0] pa_q, down_q, nx, ny, fill_right;
    logic [TW-1:0] wr_addr;
    logic          tbl_we;
    logic [IW-1:0] tbl_wd;

    always_comb
    begin
        case (pass_reg)
            2'd0:    begin nx = cnt_reg[0]; ny = cnt_reg[1]; end
            2'd1:    begin nx = cnt_reg[0]; ny = cnt_reg[2]; end
            default: begin nx = cc_reg[0];  ny = cc_reg[1];  end
        endcase
    end

    function automatic logic [TW-1:0] taddr(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                            input logic [IW-1:0] w);
        return TW'((32'(r) * (32'(w) + 32'd1)) + 32'(c));
    endfunction

    logic [IW-1:0] i_p1, j_p1;
    assign i_p1 = i_reg + IW'(1);
    assign j_p1 = j_reg + IW'(1);

    logic [TW-1:0] rd_addr;
    logic          rd_zero;
    assign rd_addr = (state_reg == ST_TRACE_RD) ? taddr(i_reg, j_p1, ny)
                                                : taddr(i_p1, j_p1, ny);
    assign rd_zero = (state_reg == ST_TRACE_RD) ? (j_p1 >= ny) : (i_p1 >= nx || j_p1 >= ny);
    assign fill_right = (j_p1 >= ny) ? '0 : prev_reg;

    // registered reads of digests and table neighbors
    always_ff @(posedge clk)
    begin
        case (pass_reg)
            2'd0:    begin x_q <= orig_mem[i_reg[AW-1:0]]; y_q <= a_mem[j_reg[AW-1:0]]; end
            2'd1:    begin x_q <= orig_mem[i_reg[AW-1:0]]; y_q <= b_mem[j_reg[AW-1:0]]; end
            default: begin x_q <= coa_mem[i_reg[AW-1:0]];  y_q <= cob_mem[j_reg[AW-1:0]]; end
        endcase
        pa_q    <= rd_zero ? '0 : tbl[rd_addr];
        down_q  <= (i_p1 >= nx) ? '0 : tbl[taddr(i_p1, j_reg, ny)];
        xd      <= a_mem[ac_reg[AW-1:0]];
        yd      <= b_mem[bc_reg[AW-1:0]];
        ca_q    <= call_mem[lc_reg[AW-1:0]];
        coa_q   <= coa_mem[a1_reg[AW-1:0]];
        cob_q   <= cob_mem[b1_reg[AW-1:0]];
        if (tbl_we)
            tbl[wr_addr] <= tbl_wd;
    end

    logic eq_xy, in_take;
    logic [IW-1:0] cell_v;
    assign eq_xy   = (x_q == y_q);
    assign cell_v  = eq_xy ? pa_q + IW'(1) : ((down_q >= fill_right) ? down_q : fill_right);
    assign wr_addr = taddr(i_reg, j_reg, ny);
    assign tbl_we  = (state_reg == ST_FILL_WR);
    assign tbl_wd  = cell_v;
    assign in_take = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_data  = res_reg;

    logic [DIGEST_W-1:0] ld_dig;
    assign ld_dig = {in_data.digest_high, in_data.digest_middle, in_data.digest_low};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_take && in_data.func == FUNC_LOAD)
        begin
            case (in_data.which_file)
                FILE_ORIG: if (cnt_reg[0] < IW'(MAX_LINES)) orig_mem[cnt_reg[0][AW-1:0]] <= ld_dig;
                FILE_A:    if (cnt_reg[1] < IW'(MAX_LINES)) a_mem[cnt_reg[1][AW-1:0]] <= ld_dig;
                FILE_B:    if (cnt_reg[2] < IW'(MAX_LINES)) b_mem[cnt_reg[2][AW-1:0]] <= ld_dig;
                default: ;
            endcase
        end
        if (state_reg == ST_TRACE_DO && eq_xy && n_reg < IW'(MAX_LINES))
        begin
            case (pass_reg)
                2'd0:    coa_mem[n_reg[AW-1:0]]  <= x_q;
                2'd1:    cob_mem[n_reg[AW-1:0]]  <= x_q;
                default: call_mem[n_reg[AW-1:0]] <= x_q;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= '0;
            i_reg <= '0; j_reg <= '0; n_reg <= '0;
            ac_reg <= '0; bc_reg <= '0; a1_reg <= '0; b1_reg <= '0;
            lc_reg <= '0; er_reg <= '0;
            prev_reg <= '0;
            res_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                cnt_reg[k] <= '0;
                cc_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            i_reg <= i_next; j_reg <= j_next; n_reg <= n_next;
            ac_reg <= ac_next; bc_reg <= bc_next; a1_reg <= a1_next; b1_reg <= b1_next;
            lc_reg <= lc_next; er_reg <= er_next;
            prev_reg <= prev_next;
            res_reg <= res_next;
            if (state_reg == ST_IDLE && in_take && in_data.func == FUNC_LOAD)
            begin
                for (int k = 0; k < 3; k++)
                    if (in_data.which_file == 2'(k) && cnt_reg[k] < IW'(MAX_LINES))
                        cnt_reg[k] <= cnt_reg[k] + IW'(1);
            end
            if (state_reg == ST_TRACE_DO && !(i_reg < nx && j_reg < ny))
                cc_reg[pass_reg] <= n_reg;
            if (state_reg == ST_CLEAR)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cnt_reg[k] <= '0;
                    cc_reg[k]  <= '0;
                end
            end
        end
    end

    logic more_a, more_b;
    assign more_a = ac_reg < cnt_reg[1];
    assign more_b = bc_reg < cnt_reg[2];

    always_comb
    begin
        state_next = state_reg;
        pass_next = pass_reg;
        i_next = i_reg; j_next = j_reg; n_next = n_reg;
        ac_next = ac_reg; bc_next = bc_reg; a1_next = a1_reg; b1_next = b1_reg;
        lc_next = lc_reg; er_next = er_reg;
        prev_next = prev_reg;
        res_next = res_reg;
        case (state_reg)
            ST_IDLE:
                if (in_take && in_data.func == FUNC_RUN)
                begin
                    pass_next = 2'd0;
                    state_next = ST_FILL_RD;
                    i_next = cnt_reg[0] - IW'(1);
                    j_next = cnt_reg[1] - IW'(1);
                    if (cnt_reg[0] == '0 || cnt_reg[1] == '0)
                    begin
                        state_next = ST_TRACE_RD;
                        i_next = '0; j_next = '0;
                    end
                    n_next = '0;
                end
            ST_FILL_RD:
                state_next = ST_FILL_WR;
            ST_FILL_WR:
            begin
                state_next = ST_FILL_RD;
                prev_next = cell_v;
                if (j_reg != '0)
                    j_next = j_reg - IW'(1);
                else if (i_reg != '0)
                begin
                    i_next = i_reg - IW'(1);
                    j_next = ny - IW'(1);
                end
                else
                begin
                    state_next = ST_TRACE_RD;
                    i_next = '0; j_next = '0;
                end
            end
            ST_TRACE_RD:
                state_next = ST_TRACE_DO;
            ST_TRACE_DO:
                if (i_reg < nx && j_reg < ny)
                begin
                    state_next = ST_TRACE_RD;
                    if (eq_xy)
                    begin
                        if (n_reg < IW'(MAX_LINES))
                            n_next = n_reg + IW'(1);
                        i_next = i_p1; j_next = j_p1;
                    end
                    else if (down_q >= pa_q)
                        i_next = i_p1;
                    else
                        j_next = j_p1;
                end
                else
                begin
                    n_next = '0;
                    if (pass_reg == 2'd2)
                    begin
                        state_next = ST_MERGE_RD;
                        ac_next = '0; bc_next = '0; a1_next = '0; b1_next = '0;
                        lc_next = '0; er_next = '0;
                    end
                    else
                    begin
                        pass_next = pass_reg + 2'd1;
                        i_next = '0; j_next = '0;
                        state_next = ST_TRACE_RD;
                        if (pass_reg == 2'd0 && cnt_reg[0] != '0 && cnt_reg[2] != '0)
                        begin
                            state_next = ST_FILL_RD;
                            i_next = cnt_reg[0] - IW'(1);
                            j_next = cnt_reg[2] - IW'(1);
                        end
                        else if (pass_reg == 2'd1 && cc_reg[0] != '0 && n_reg != '0)
                        begin
                            state_next = ST_FILL_RD;
                            i_next = cc_reg[0] - IW'(1);
                            j_next = n_reg - IW'(1);
                        end
                    end
                end
            ST_MERGE_RD:
                state_next = (more_a || more_b) ? ST_MERGE_DO : ST_CLEAR;
            ST_MERGE_DO:
            begin
                state_next = ST_EMIT;
                res_next.conflict_total = LINE_W'(er_reg);
                res_next.a_line = '0;
                res_next.b_line = '0;
                if (more_a && more_b)
                begin
                    if (xd == yd)
                    begin
                        res_next.kind = KIND_A; res_next.a_line = LINE_W'(ac_reg + IW'(1));
                        ac_next = ac_reg + IW'(1); a1_next = a1_reg + IW'(1);
                        bc_next = bc_reg + IW'(1); b1_next = b1_reg + IW'(1);
                        lc_next = lc_reg + IW'(1);
                    end
                    else if (lc_reg < cc_reg[2] && xd == ca_q)
                    begin
                        res_next.kind = KIND_B; res_next.b_line = LINE_W'(bc_reg + IW'(1));
                        bc_next = bc_reg + IW'(1);
                    end
                    else if (lc_reg < cc_reg[2] && yd == ca_q)
                    begin
                        res_next.kind = KIND_A; res_next.a_line = LINE_W'(ac_reg + IW'(1));
                        ac_next = ac_reg + IW'(1);
                    end
                    else if (a1_reg < cc_reg[0] && xd == coa_q)
                    begin
                        res_next.kind = KIND_B; res_next.b_line = LINE_W'(bc_reg + IW'(1));
                        ac_next = ac_reg + IW'(1); a1_next = a1_reg + IW'(1);
                        bc_next = bc_reg + IW'(1);
                    end
                    else if (b1_reg < cc_reg[1] && yd == cob_q)
                    begin
                        res_next.kind = KIND_A; res_next.a_line = LINE_W'(ac_reg + IW'(1));
                        bc_next = bc_reg + IW'(1); b1_next = b1_reg + IW'(1);
                        ac_next = ac_reg + IW'(1);
                    end
                    else
                    begin
                        er_next = er_reg + IW'(1);
                        res_next.kind = KIND_CONFLICT;
                        res_next.a_line = LINE_W'(ac_reg + IW'(1));
                        res_next.b_line = LINE_W'(bc_reg + IW'(1));
                        res_next.conflict_total = LINE_W'(er_reg + IW'(1));
                        ac_next = ac_reg + IW'(1); bc_next = bc_reg + IW'(1);
                    end
                end
                else if (more_a)
                begin
                    res_next.kind = KIND_A; res_next.a_line = LINE_W'(ac_reg + IW'(1));
                    ac_next = ac_reg + IW'(1);
                end
                else
                begin
                    res_next.kind = KIND_B; res_next.b_line = LINE_W'(bc_reg + IW'(1));
                    bc_next = bc_reg + IW'(1);
                end
                res_next.last = !(ac_next < cnt_reg[1] || bc_next < cnt_reg[2]);
            end
            ST_EMIT:
                if (!out_stall)
                    state_next = res_reg.last ? ST_CLEAR : ST_MERGE_RD;
            ST_CLEAR:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input accepted during run");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("result dropped under stall");
    a_conflict_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE_DO && state_next == ST_EMIT) |=> (er_reg >= $past(er_reg)))
        else $error("conflict count went back");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last) |=> (state_reg == ST_CLEAR))
        else $error("no clear after last");
`endif

endmodule

// ===== verif/three_way_line_merge_top_tb.sv =====
module three_way_line_merge_top_tb;
    import twlm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXL = 32;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    three_way_line_merge_top #(.MAX_LINES(MAXL)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    logic [159:0] orig_lines[MAXL];
    logic [159:0] a_lines[MAXL];
    logic [159:0] b_lines[MAXL];
    int           file_len[3];
    out_item_t    merged_q[$];
    int           error_count;
    longint       cycle_count;
    bit           idle_enable;
    int           send_gap;

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int lcs_of(input logic [159:0] x[MAXL], input int nx,
                                  input logic [159:0] y[MAXL], input int ny,
                                  output logic [159:0] dst[MAXL]);
        int tbl[MAXL+1][MAXL+1];
        int i;
        int j;
        int n;
        for (i = 0; i <= MAXL; i++)
            for (j = 0; j <= MAXL; j++)
                tbl[i][j] = 0;
        for (i = nx - 1; i >= 0; i--)
            for (j = ny - 1; j >= 0; j--)
                if (x[i] == y[j])
                    tbl[i][j] = tbl[i+1][j+1] + 1;
                else
                    tbl[i][j] = (tbl[i+1][j] >= tbl[i][j+1]) ? tbl[i+1][j] : tbl[i][j+1];
        i = 0;
        j = 0;
        n = 0;
        for (int d = 0; d < MAXL; d++)
            dst[d] = '0;
        while (i < nx && j < ny)
        begin
            if (x[i] == y[j])
            begin
                dst[n] = x[i];
                n++;
                i++;
                j++;
            end
            else if (tbl[i+1][j] >= tbl[i][j+1])
                i++;
            else
                j++;
        end
        return n;
    endfunction

    task automatic push_merged(input logic [1:0] kind, input int al, input int bl,
                               input int conf);
        out_item_t r;
        r.kind = kind;
        r.a_line = al[5:0];
        r.b_line = bl[5:0];
        r.conflict_total = conf[5:0];
        r.last = 1'b0;
        merged_q.push_back(r);
    endtask

    task automatic predict_merge();
        logic [159:0] com_oa[MAXL];
        logic [159:0] com_ob[MAXL];
        logic [159:0] com_all[MAXL];
        int c0;
        int c1;
        int c2;
        int na;
        int nb;
        int ac;
        int bc;
        int a1c;
        int b1c;
        int lc;
        int errs;
        int base;
        na = file_len[1];
        nb = file_len[2];
        c0 = lcs_of(orig_lines, file_len[0], a_lines, na, com_oa);
        c1 = lcs_of(orig_lines, file_len[0], b_lines, nb, com_ob);
        c2 = lcs_of(com_oa, c0, com_ob, c1, com_all);
        ac = 0; bc = 0; a1c = 0; b1c = 0; lc = 0; errs = 0;
        base = merged_q.size();
        while (ac < na || bc < nb)
        begin
            if (ac < na && bc < nb)
            begin
                if (a_lines[ac] == b_lines[bc])
                begin
                    push_merged(KIND_A, ac + 1, 0, errs);
                    ac++; a1c++; bc++; b1c++; lc++;
                end
                else if (lc < c2 && a_lines[ac] == com_all[lc])
                begin
                    push_merged(KIND_B, 0, bc + 1, errs);
                    bc++;
                end
                else if (lc < c2 && b_lines[bc] == com_all[lc])
                begin
                    push_merged(KIND_A, ac + 1, 0, errs);
                    ac++;
                end
                else if (a1c < c0 && a_lines[ac] == com_oa[a1c])
                begin
                    push_merged(KIND_B, 0, bc + 1, errs);
                    ac++; a1c++; bc++;
                end
                else if (b1c < c1 && b_lines[bc] == com_ob[b1c])
                begin
                    push_merged(KIND_A, ac + 1, 0, errs);
                    bc++; b1c++; ac++;
                end
                else
                begin
                    errs++;
                    push_merged(KIND_CONFLICT, ac + 1, bc + 1, errs);
                    ac++; bc++;
                end
            end
            else if (ac < na)
            begin
                push_merged(KIND_A, ac + 1, 0, errs);
                ac++;
            end
            else
            begin
                push_merged(KIND_B, 0, bc + 1, errs);
                bc++;
            end
        end
        if (merged_q.size() > base)
            merged_q[merged_q.size() - 1].last = 1'b1;
        file_len[0] = 0;
        file_len[1] = 0;
        file_len[2] = 0;
    endtask

    task automatic predict_item(input in_item_t it);
        logic [159:0] d;
        int f;
        if (it.func == FUNC_RUN)
        begin
            predict_merge();
            return;
        end
        f = it.which_file;
        if (f > 2 || file_len[f] >= MAXL)
            return;
        d = {it.digest_high, it.digest_middle, it.digest_low};
        if (f == 0)
            orig_lines[file_len[f]] = d;
        else if (f == 1)
            a_lines[file_len[f]] = d;
        else
            b_lines[file_len[f]] = d;
        file_len[f]++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_item(input in_item_t it);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            send_gap = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (send_gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(it);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (merged_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic in_item_t load_of(input logic [1:0] f, input logic [159:0] d);
        in_item_t it;
        it.func = FUNC_LOAD;
        it.which_file = f;
        {it.digest_high, it.digest_middle, it.digest_low} = d;
        return it;
    endfunction

    function automatic in_item_t run_of();
        in_item_t it;
        it.func = FUNC_RUN;
        it.which_file = 2'($urandom);
        it.digest_high = {$urandom, $urandom};
        it.digest_middle = {$urandom, $urandom};
        it.digest_low = $urandom;
        return it;
    endfunction

    function automatic logic [159:0] rand_digest();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic test_directed();
        logic [159:0] ones;
        ones = '1;
        send_item(run_of());
        send_item(load_of(FILE_ORIG, '0));
        send_item(load_of(FILE_ORIG, ones));
        send_item(load_of(FILE_A, ones));
        send_item(load_of(FILE_A, 160'h5));
        send_item(load_of(FILE_B, '0));
        send_item(load_of(FILE_B, 160'h7));
        send_item(load_of(2'd3, ones));
        send_item(run_of());
        wait_drained();
        send_item(load_of(FILE_ORIG, 160'h1));
        send_item(run_of());
        wait_drained();
        send_item(load_of(FILE_B, ones));
        send_item(load_of(FILE_B, 160'h3));
        send_item(run_of());
        wait_drained();
        for (int k = 0; k < MAXL + 2; k++)
            send_item(load_of(FILE_A, 160'(k % 3)));
        send_item(run_of());
        wait_drained();
    endtask

    task automatic test_random_merges();
        logic [159:0] pool[6];
        int nlines;
        int nload;
        int items;
        in_item_t it;
        items = 0;
        while (items < 300)
        begin
            for (int p = 0; p < 6; p++)
                pool[p] = rand_digest();
            nlines = ($urandom_range(0, 9) == 0) ? MAXL + 1 : $urandom_range(0, 8);
            for (int f = 0; f < 3; f++)
            begin
                nload = nlines - int'($urandom_range(0, 2));
                if (nload < 0)
                    nload = 0;
                for (int k = 0; k < nload; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        it = load_of(2'($urandom_range(0, 3)), rand_digest());
                    else
                        it = load_of(2'(f), pool[$urandom_range(0, 5)]);
                    send_item(it);
                    items++;
                end
            end
            send_item(run_of());
            items++;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
            if (items > 250)
                idle_enable = 1'b0;
        end
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (idle_enable && !out_stall && $urandom_range(0, 5) == 0)
            out_stall <= 1'b1;
        else if (out_stall && (!idle_enable || $urandom_range(0, 3) == 0))
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (merged_q.size() == 0)
                report_mismatch("unexpected transfer", 1, 0);
            else
            begin
                want = merged_q.pop_front();
                if (out_data.kind !== want.kind)
                    report_mismatch("kind", out_data.kind, want.kind);
                if (out_data.a_line !== want.a_line)
                    report_mismatch("a_line", out_data.a_line, want.a_line);
                if (out_data.b_line !== want.b_line)
                    report_mismatch("b_line", out_data.b_line, want.b_line);
                if (out_data.conflict_total !== want.conflict_total)
                    report_mismatch("conflict_total", out_data.conflict_total,
                                    want.conflict_total);
                if (out_data.last !== want.last)
                    report_mismatch("last", out_data.last, want.last);
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        error_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        file_len[0] = 0;
        file_len[1] = 0;
        file_len[2] = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_merges();
        if (merged_q.size() != 0)
            report_mismatch("results left over", merged_q.size(), 0);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/twlm_pkg.sv
rtl/core/three_way_line_merge_top.sv
verif/three_way_line_merge_top_tb.sv
